// ===== rtl/grr_pkg.sv =====
// ----------------------------------------------------------------------------
// grr_pkg
// Shared types and constants for the gamma ramp resampler: item layouts,
// register indexes, lane control and status, divider sizing.
// ----------------------------------------------------------------------------
package grr_pkg;

   // table and field sizing
   localparam int TABLE_DEPTH = 1024;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int VAL_W       = 16;
   localparam int POS_W       = 16;
   localparam int FILE_W      = 11;
   localparam int RAMP_W      = 17;
   localparam int BYTES_W     = 2;
   localparam int CSR_W       = 17;
   localparam int CSR_IDX_W   = 2;
   localparam int IDX_W       = FILE_W + POS_W;
   localparam int LANES       = 3;

   // divider sizing: 17-bit divisor, one quotient bit per cycle
   localparam int DIV_W  = 17;
   localparam int STEP_W = 5;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FILE_ENTRIES = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_RAMP_ENTRIES = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ENTRY_BYTES  = 2'd2;

   // register reset values
   localparam logic [FILE_W-1:0]  FILE_ENTRIES_RST = 11'd256;
   localparam logic [RAMP_W-1:0]  RAMP_ENTRIES_RST = 17'd256;
   localparam logic [BYTES_W-1:0] ENTRY_BYTES_RST  = 2'd2;
   localparam logic [BYTES_W-1:0] ENTRY_BYTES_ONE  = 2'd1;

   // item actions
   localparam logic ACT_LOAD  = 1'b0;
   localparam logic ACT_QUERY = 1'b1;

   // top value rules and byte entry shift
   localparam logic [VAL_W-1:0] TOP_FLOOR  = 16'h4000;
   localparam logic [VAL_W-1:0] TOP_FORCED = 16'hffff;
   localparam int               BYTE_SHIFT = 8;

   typedef struct packed {
      logic             action;
      logic [POS_W-1:0] position;
      logic [VAL_W-1:0] load_red;
      logic [VAL_W-1:0] load_green;
      logic [VAL_W-1:0] load_blue;
   } req_item_type;

   typedef struct packed {
      logic [VAL_W-1:0] ramp_red;
      logic [VAL_W-1:0] ramp_green;
      logic [VAL_W-1:0] ramp_blue;
      logic             in_range;
   } rsp_item_type;

   // per-cycle operation a lane performs
   typedef enum logic [2:0] {
      LOP_IDLE,
      LOP_CAP_LAST,
      LOP_CAP_PREV,
      LOP_CAP_A,
      LOP_CAP_B,
      LOP_TOP,
      LOP_MUL,
      LOP_DIV
   } lane_op_type;

   typedef struct packed {
      logic              wr_en;
      logic [ADDR_W-1:0] wr_addr;
      logic              byte_mode;
      logic              rd_en;
      logic [ADDR_W-1:0] rd_addr;
      lane_op_type       op;
      logic [DIV_W-1:0]  ratio;
      logic [DIV_W-1:0]  frac;
      logic              direct;
      logic              past_end;
      logic              b_top;
   } lane_ctl_type;

   typedef struct packed {
      logic             done;
      logic [VAL_W-1:0] value;
   } lane_stat_type;

endpackage

// ===== rtl/grr_divider.sv =====
// ----------------------------------------------------------------------------
// grr_divider
// Restoring divider, one quotient bit per cycle. The dividend is given as an
// upper part that must be below the divisor and a lower part that is shifted
// in MSB first for the given number of steps.
// ----------------------------------------------------------------------------
module grr_divider (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [grr_pkg::DIV_W-1:0]  divisor,
   input  logic [grr_pkg::DIV_W-1:0]  num_hi,
   input  logic [grr_pkg::DIV_W-1:0]  num_lo,
   input  logic [grr_pkg::STEP_W-1:0] steps,
   output logic                       done,
   output logic [grr_pkg::DIV_W-1:0]  quotient,
   output logic [grr_pkg::DIV_W-1:0]  remainder
);
   import grr_pkg::*;

   logic              busy_ff;
   logic              done_ff;
   logic [STEP_W-1:0] cnt_ff;
   logic [STEP_W-1:0] steps_ff;
   logic [DIV_W-1:0]  rem_ff;
   logic [DIV_W-1:0]  sh_ff;
   logic [DIV_W-1:0]  div_ff;

   logic [DIV_W:0]    trial;
   logic [DIV_W:0]    diff;
   logic              ge;
   logic [DIV_W-1:0]  rem_in;
   logic [DIV_W-1:0]  sh_in;
   logic              last_step;

   // one trial subtraction per cycle
   always_comb begin
      trial     = {rem_ff, sh_ff[DIV_W-1]};
      diff      = trial - {1'b0, div_ff};
      ge        = trial >= {1'b0, div_ff};
      rem_in    = ge ? diff[DIV_W-1:0] : trial[DIV_W-1:0];
      sh_in     = {sh_ff[DIV_W-2:0], ge};
      last_step = cnt_ff == (steps_ff - STEP_W'(1));
   end

   // control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= '0;
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + STEP_W'(1);
            if (last_step) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (start) begin
         rem_ff   <= num_hi;
         sh_ff    <= num_lo;
         div_ff   <= divisor;
         steps_ff <= steps;
      end else if (busy_ff) begin
         rem_ff <= rem_in;
         sh_ff  <= sh_in;
      end
   end

   assign done      = done_ff;
   assign quotient  = sh_ff;
   assign remainder = rem_ff;

endmodule

// ===== rtl/grr_lane.sv =====
// ----------------------------------------------------------------------------
// grr_lane
// One color channel: its calibration table, the fetched neighbors, the top
// value, the weighted mix and the division by the ratio.
// ----------------------------------------------------------------------------
module grr_lane (
   input  logic                      clock,
   input  logic                      reset,
   input  grr_pkg::lane_ctl_type     ctl,
   input  logic [grr_pkg::VAL_W-1:0] wr_data,
   output grr_pkg::lane_stat_type    stat
);
   import grr_pkg::*;

   logic [VAL_W-1:0] mem [TABLE_DEPTH];
   logic [VAL_W-1:0] rd_data_ff;
   logic [VAL_W-1:0] last_ff;
   logic [VAL_W-1:0] prev_ff;
   logic [VAL_W-1:0] a_ff;
   logic [VAL_W-1:0] b_ff;
   logic [VAL_W-1:0] top_ff;
   logic [VAL_W+DIV_W-1:0] pa_ff;
   logic [VAL_W+DIV_W-1:0] pb_ff;

   logic [VAL_W-1:0] wr_value;
   logic [VAL_W-1:0] twice;
   logic [VAL_W-1:0] top_in;
   logic [VAL_W-1:0] b_eff;
   logic [DIV_W-1:0] weight_a;
   logic [VAL_W+DIV_W:0] mix_sum;
   logic [DIV_W-1:0] div_hi;
   logic [DIV_W-1:0] div_lo;
   logic             div_done;
   logic [DIV_W-1:0] div_quo;
   logic [DIV_W-1:0] div_rem;

   // byte entries sit in the upper byte
   assign wr_value = ctl.byte_mode ? (VAL_W'(wr_data[7:0]) << BYTE_SHIFT) : wr_data;

   // table memory, registered read
   always_ff @(posedge clock) begin
      if (ctl.wr_en) begin
         mem[ctl.wr_addr] <= wr_value;
      end
      if (ctl.rd_en) begin
         rd_data_ff <= mem[ctl.rd_addr];
      end
   end

   // extrapolated top value
   always_comb begin
      twice  = {last_ff[VAL_W-2:0], 1'b0} - prev_ff;
      top_in = (twice < TOP_FLOOR) ? TOP_FORCED : twice;
   end

   // weights of the two neighbors
   assign weight_a = ctl.ratio - ctl.frac;
   assign b_eff    = ctl.b_top ? top_ff : b_ff;

   // the weighted sum stays below 2^16 times the ratio
   always_comb begin
      mix_sum = {1'b0, pa_ff} + {1'b0, pb_ff};
      div_hi  = DIV_W'(mix_sum[2*VAL_W-1:VAL_W]);
      div_lo  = {mix_sum[VAL_W-1:0], 1'b0};
   end

   // captures and products
   always_ff @(posedge clock) begin
      case (ctl.op)
         LOP_CAP_LAST: last_ff <= rd_data_ff;
         LOP_CAP_PREV: prev_ff <= rd_data_ff;
         LOP_CAP_A:    a_ff    <= rd_data_ff;
         LOP_CAP_B:    b_ff    <= rd_data_ff;
         LOP_TOP:      top_ff  <= top_in;
         LOP_MUL: begin
            pa_ff <= a_ff * weight_a;
            pb_ff <= b_eff * ctl.frac;
         end
         default: ;
      endcase
   end

   grr_divider u_div (
      .clock     (clock),
      .reset     (reset),
      .start     (ctl.op == LOP_DIV),
      .divisor   (ctl.ratio),
      .num_hi    (div_hi),
      .num_lo    (div_lo),
      .steps     (STEP_W'(VAL_W)),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // final value of this channel
   always_comb begin
      stat.done = div_done;
      if (ctl.direct) begin
         stat.value = a_ff;
      end else if (ctl.past_end) begin
         stat.value = top_ff;
      end else begin
         stat.value = div_quo[VAL_W-1:0] | (VAL_W'(div_rem) & '0);
      end
   end

endmodule

// ===== rtl/gamma_ramp_resampler_core.sv =====
// ----------------------------------------------------------------------------
// gamma_ramp_resampler_core
// Three-channel calibration table resampled onto a gamma ramp. A sequencer
// computes the ratio and the table position once; three lanes then fetch in
// parallel, mix and divide when interpolating, and are merged into one result.
// ----------------------------------------------------------------------------
// load items: no result, busy stays low
// out-of-range queries: result in the cycle after acceptance, busy stays low
// in-range queries: radix-2 ratio division, then a multiply if the ramp is no
//   longer than the table, else position and, when interpolating, lane divisions
// one query at a time; the next item is taken in the cycle the result shows
// synchronous reset clears control, restores config; data and table are kept
// ----------------------------------------------------------------------------
module gamma_ramp_resampler_core (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  grr_pkg::req_item_type         req_item,
   input  logic                          csr_we,
   input  logic [grr_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [grr_pkg::CSR_W-1:0]     csr_wdata,
   output logic                          rsp_valid,
   output grr_pkg::rsp_item_type         rsp_item
);
   import grr_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RATIO,
      ST_IDX,
      ST_CLIP,
      ST_SPLIT,
      ST_RD0,
      ST_RD1,
      ST_RD2,
      ST_RD3,
      ST_RD4,
      ST_TOP,
      ST_MUL,
      ST_DIV,
      ST_WAIT,
      ST_FIN
   } state_type;

   // configuration registers
   logic [FILE_W-1:0]  file_entries_ff;
   logic [RAMP_W-1:0]  ramp_entries_ff;
   logic [BYTES_W-1:0] entry_bytes_ff;

   // sequencer registers
   state_type        state_ff;
   logic [POS_W-1:0] pos_ff;
   logic [FILE_W-1:0] f_ff;
   logic             direct_ff;
   logic [DIV_W-1:0] ratio_ff;
   logic [IDX_W-1:0] idx_ff;
   logic [POS_W-1:0] j_ff;
   logic [DIV_W-1:0] i_ff;
   logic             past_end_ff;
   logic             b_top_ff;
   logic             rsp_valid_ff;
   rsp_item_type     rsp_item_ff;

   logic              accept;
   logic              is_query;
   logic              pos_in_range;
   logic [FILE_W-1:0] f_sat;
   logic              direct_now;
   logic              div_start;
   logic [DIV_W-1:0]  div_divisor;
   logic [DIV_W-1:0]  div_lo;
   logic [STEP_W-1:0] div_steps;
   logic              div_done;
   logic [DIV_W-1:0]  div_quo;
   logic [DIV_W-1:0]  div_rem;
   logic              lanes_done;
   rsp_item_type      merged;
   lane_ctl_type      ctl;
   lane_stat_type     stat [LANES];
   logic [VAL_W-1:0]  lane_wr [LANES];

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         file_entries_ff <= FILE_ENTRIES_RST;
         ramp_entries_ff <= RAMP_ENTRIES_RST;
         entry_bytes_ff  <= ENTRY_BYTES_RST;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_FILE_ENTRIES: file_entries_ff <= csr_wdata[FILE_W-1:0];
            CSR_RAMP_ENTRIES: ramp_entries_ff <= csr_wdata[RAMP_W-1:0];
            CSR_ENTRY_BYTES:  entry_bytes_ff  <= csr_wdata[BYTES_W-1:0];
            default: ;
         endcase
      end
   end

   // item decode and table length saturation
   always_comb begin
      accept       = start && (state_ff == ST_IDLE);
      is_query     = req_item.action == ACT_QUERY;
      pos_in_range = {1'b0, req_item.position} < ramp_entries_ff;
      if (file_entries_ff < FILE_W'(2)) begin
         f_sat = FILE_W'(2);
      end else if (file_entries_ff > FILE_W'(TABLE_DEPTH)) begin
         f_sat = FILE_W'(TABLE_DEPTH);
      end else begin
         f_sat = file_entries_ff;
      end
      direct_now = RAMP_W'(f_sat) >= ramp_entries_ff;
   end

   // shared divider operands: ratio first, then position split when not direct
   always_comb begin
      div_start   = 1'b0;
      div_divisor = '0;
      div_lo      = '0;
      div_steps   = STEP_W'(DIV_W);
      if (state_ff == ST_IDLE) begin
         div_start = accept && is_query && pos_in_range;
         if (direct_now) begin
            div_divisor = ramp_entries_ff;
            div_lo      = DIV_W'(f_sat);
         end else begin
            div_divisor = DIV_W'(f_sat);
            div_lo      = ramp_entries_ff;
         end
      end else if (state_ff == ST_RATIO) begin
         div_start   = div_done && !direct_ff;
         div_divisor = div_quo;
         div_lo      = {pos_ff, 1'b0};
         div_steps   = STEP_W'(POS_W);
      end
   end

   grr_divider u_ctl_div (
      .clock     (clock),
      .reset     (reset),
      .start     (div_start),
      .divisor   (div_divisor),
      .num_hi    ('0),
      .num_lo    (div_lo),
      .steps     (div_steps),
      .done      (div_done),
      .quotient  (div_quo),
      .remainder (div_rem)
   );

   // lane control
   always_comb begin
      ctl           = '0;
      ctl.op        = LOP_IDLE;
      ctl.wr_en     = accept && !is_query &&
                      ({1'b0, req_item.position} < (POS_W+1)'(TABLE_DEPTH));
      ctl.wr_addr   = req_item.position[ADDR_W-1:0];
      ctl.byte_mode = entry_bytes_ff == ENTRY_BYTES_ONE;
      ctl.ratio     = ratio_ff;
      ctl.frac      = i_ff;
      ctl.direct    = direct_ff;
      ctl.past_end  = past_end_ff;
      ctl.b_top     = b_top_ff;
      unique case (state_ff)
         ST_RD0: begin
            ctl.rd_en   = 1'b1;
            ctl.rd_addr = ADDR_W'(f_ff - FILE_W'(1));
         end
         ST_RD1: begin
            ctl.rd_en   = 1'b1;
            ctl.rd_addr = ADDR_W'(f_ff - FILE_W'(2));
            ctl.op      = LOP_CAP_LAST;
         end
         ST_RD2: begin
            ctl.rd_en   = 1'b1;
            ctl.rd_addr = j_ff[ADDR_W-1:0];
            ctl.op      = LOP_CAP_PREV;
         end
         ST_RD3: begin
            ctl.rd_en   = 1'b1;
            ctl.rd_addr = b_top_ff ? j_ff[ADDR_W-1:0] : ADDR_W'(j_ff + POS_W'(1));
            ctl.op      = LOP_CAP_A;
         end
         ST_RD4: ctl.op = LOP_CAP_B;
         ST_TOP: ctl.op = LOP_TOP;
         ST_MUL: ctl.op = LOP_MUL;
         ST_DIV: ctl.op = LOP_DIV;
         default: ;
      endcase
   end

   // channel lanes
   assign lane_wr[0] = req_item.load_red;
   assign lane_wr[1] = req_item.load_green;
   assign lane_wr[2] = req_item.load_blue;

   for (genvar g = 0; g < LANES; g++) begin : g_lane
      grr_lane u_lane (
         .clock   (clock),
         .reset   (reset),
         .ctl     (ctl),
         .wr_data (lane_wr[g]),
         .stat    (stat[g])
      );
   end

   // merge of the lane values
   always_comb begin
      lanes_done          = stat[0].done && stat[1].done && stat[2].done;
      merged.ramp_red     = stat[0].value;
      merged.ramp_green   = stat[1].value;
      merged.ramp_blue    = stat[2].value;
      merged.in_range     = 1'b1;
   end

   // sequencer
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (accept && is_query) begin
                  pos_ff    <= req_item.position;
                  f_ff      <= f_sat;
                  direct_ff <= direct_now;
                  if (pos_in_range) begin
                     state_ff <= ST_RATIO;
                  end else begin
                     rsp_valid_ff <= 1'b1;
                     rsp_item_ff  <= '0;
                  end
               end
            end
            ST_RATIO: begin
               if (div_done) begin
                  ratio_ff <= div_quo;
                  state_ff <= direct_ff ? ST_IDX : ST_SPLIT;
               end
            end
            ST_IDX: begin
               idx_ff   <= ratio_ff[FILE_W-1:0] * pos_ff;
               i_ff     <= '0;
               state_ff <= ST_CLIP;
            end
            ST_CLIP: begin
               j_ff     <= (idx_ff >= IDX_W'(f_ff)) ? POS_W'(f_ff - FILE_W'(1))
                                                    : idx_ff[POS_W-1:0];
               state_ff <= ST_RD0;
            end
            ST_SPLIT: begin
               if (div_done) begin
                  j_ff     <= div_quo[POS_W-1:0];
                  i_ff     <= div_rem;
                  state_ff <= ST_RD0;
               end
            end
            ST_RD0: begin
               past_end_ff <= !direct_ff && (j_ff >= POS_W'(f_ff));
               b_top_ff    <= ((POS_W+1)'(j_ff) + (POS_W+1)'(1)) >= (POS_W+1)'(f_ff);
               state_ff    <= ST_RD1;
            end
            ST_RD1: state_ff <= ST_RD2;
            ST_RD2: state_ff <= ST_RD3;
            ST_RD3: state_ff <= ST_RD4;
            ST_RD4: state_ff <= ST_TOP;
            ST_TOP: state_ff <= (direct_ff || past_end_ff) ? ST_FIN : ST_MUL;
            ST_MUL: state_ff <= ST_DIV;
            ST_DIV: state_ff <= ST_WAIT;
            ST_WAIT: begin
               if (lanes_done) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_item_ff  <= merged;
                  state_ff     <= ST_IDLE;
               end
            end
            ST_FIN: begin
               rsp_valid_ff <= 1'b1;
               rsp_item_ff  <= merged;
               state_ff     <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign busy      = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_item_ff;

endmodule

// ===== rtl/grr_checker.sv =====
// ----------------------------------------------------------------------------
// grr_checker
// Port-level checks of the gamma ramp resampler: result timing against
// accepted items and the busy flag, and zeroed out-of-range results.
// ----------------------------------------------------------------------------
module grr_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  start,
   input logic                  busy,
   input grr_pkg::req_item_type req_item,
   input logic                  rsp_valid,
   input grr_pkg::rsp_item_type rsp_item
);
   import grr_pkg::*;

   logic load_accept;
   logic query_accept;

   assign load_accept  = start && !busy && (req_item.action == ACT_LOAD);
   assign query_accept = start && !busy && (req_item.action == ACT_QUERY);

   // a load item never produces a result
   a_load_silent: assert property (@(posedge clock) disable iff (reset)
      load_accept |=> !rsp_valid)
      else $error("result after a load item");

   // a query item either answers at once or keeps the block busy
   a_query_progress: assert property (@(posedge clock) disable iff (reset)
      query_accept |=> (rsp_valid || busy))
      else $error("query item dropped");

   // a result is only shown when the block is free again
   a_rsp_not_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result while busy");

   // the end of a query's work always shows its result
   a_done_shows: assert property (@(posedge clock) disable iff (reset)
      (!$past(reset) && $fell(busy)) |-> rsp_valid)
      else $error("busy dropped without a result");

   // out-of-range results carry zero values
   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_item.in_range) |->
         (rsp_item.ramp_red == '0 && rsp_item.ramp_green == '0 &&
          rsp_item.ramp_blue == '0))
      else $error("out-of-range result not zero");

endmodule

bind gamma_ramp_resampler_core grr_checker u_grr_checker (.*);
